[src/mm_pkg.sv]
// Shared types and constants of the matrix multiplier: item layouts, the
// link between chain cells, opcodes, register indexes and saturation values.
// Depends on nothing; every other file of the block but mm_ram imports it.
package mm_pkg;

   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int DIM_CFG_W = 4;

   localparam logic [DIM_CFG_W-1:0] DIM_RESET = 4'd8;

   localparam logic [1:0] OP_WRITE_A = 2'd0;
   localparam logic [1:0] OP_WRITE_B = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_INNER_DIM = 2'd1;
   localparam logic [1:0] REG_COLS_B    = 2'd2;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [2:0]         row_index;
      logic [2:0]         col_index;
      logic signed [31:0] element_value;
   } mm_req_type;

   typedef struct packed {
      logic [2:0]         out_row;
      logic [2:0]         out_col;
      logic signed [31:0] out_value;
      logic               saturated;
      logic               last;
   } mm_rsp_type;

   // One A element travelling down the chain of cells.
   typedef struct packed {
      logic               vld;
      logic               first;
      logic signed [31:0] a;
   } mm_link_type;

endpackage

[src/mm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/mm_cell.sv]
// One cell of the multiply chain: holds one column of B and the accumulator
// of one result column, and forwards the incoming A element to its neighbor.
// Depends on mm_pkg.
module mm_cell #(
   parameter int MAX_DIM = 8,
   parameter int IDXW    = 3,
   parameter int ACC_W   = 67
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mm_pkg::mm_link_type      link_in,
   input  logic [IDXW-1:0]          k_in,
   output mm_pkg::mm_link_type      link_out,
   output logic [IDXW-1:0]          k_out,
   input  logic                     b_we,
   input  logic [IDXW-1:0]          b_row,
   input  logic [31:0]              b_data,
   input  logic                     shift_en,
   input  logic signed [ACC_W-1:0]  acc_shift_in,
   output logic signed [ACC_W-1:0]  acc_out
);
   import mm_pkg::*;

   mm_link_type              link_ff;
   logic [IDXW-1:0]          k_ff;
   logic signed [31:0]       bcol_ff [MAX_DIM];
   logic                     prod_vld_ff;
   logic                     prod_first_ff;
   logic signed [63:0]       prod_ff;
   logic signed [63:0]       prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod_in = link_ff.a * bcol_ff[k_ff];

   always_comb begin
      acc_in = acc_ff;
      if (prod_vld_ff) begin
         acc_in = prod_first_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end else if (shift_en) begin
         acc_in = acc_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.vld <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         link_ff.vld <= link_in.vld;
         prod_vld_ff <= link_ff.vld;
      end
      link_ff.first <= link_in.first;
      link_ff.a     <= link_in.a;
      k_ff          <= k_in;
      prod_first_ff <= link_ff.first;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      if (b_we) begin
         bcol_ff[b_row] <= b_data;
      end
   end

   assign link_out = link_ff;
   assign k_out    = k_ff;
   assign acc_out  = acc_ff;

endmodule

[src/matrix_multiply.sv]
// Top level of the fixed-point matrix multiplier: sequencer, A store,
// chain of multiply cells, saturation and the configuration registers.
// Depends on mm_pkg, mm_ram and mm_cell.
//
//   port group  direction  handshake          carries
//   req_*       in         req_valid/stall    one mm_req_type item
//   rsp_*       out        rsp_valid/stall    one mm_rsp_type item
//   csr_*       in/out     APB psel/penable   rows_a, inner_dim, cols_b
//
// A write item for A or B leaves the block idle, and the block takes the next item
// in the cycle after. A compute item keeps the block busy until its last
// result row is out: per result row, the sequencer reads A from the A RAM
// (ST_FEED), waits while the last A element passes every cell (ST_WAIT),
// then shifts the row out (ST_EMIT).
// Reset is synchronous; the stores have no clearing pass.
// A stall on the result side holds the emission of the current row and the sequencer.
module matrix_multiply #(
   parameter int MAX_DIM = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  mm_pkg::mm_req_type          req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mm_pkg::mm_rsp_type          rsp_payload,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [mm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [mm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import mm_pkg::*;

   localparam int IDXW     = $clog2(MAX_DIM);
   localparam int DW       = $clog2(MAX_DIM + 1);
   localparam int DEPTH    = MAX_DIM * MAX_DIM;
   localparam int AW       = $clog2(DEPTH);
   localparam int ACC_W    = 64 + $clog2(MAX_DIM);
   localparam int SH_W     = ACC_W - 16;
   localparam int WAIT_CYC = MAX_DIM + 2;
   localparam int WW       = $clog2(WAIT_CYC);

   typedef enum logic [1:0] {ST_IDLE, ST_FEED, ST_WAIT, ST_EMIT} state_type;

   state_type              state_ff, state_in;
   logic [IDXW-1:0]        i_ff, i_in;
   logic [IDXW-1:0]        k_ff, k_in;
   logic [IDXW-1:0]        j_ff, j_in;
   logic [WW-1:0]          wait_ff, wait_in;
   logic                   feed_vld_ff, feed_vld_in;
   logic                   feed_first_ff, feed_first_in;
   logic [IDXW-1:0]        feed_k_ff, feed_k_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mm_rsp_type             rsp_payload_ff, rsp_payload_in;
   logic [DIM_CFG_W-1:0]   rows_a_ff, inner_dim_ff, cols_b_ff;

   logic [DW-1:0]          nr, nk, nc;
   logic                   req_take, in_range, csr_wr;
   logic [IDXW-1:0]        wr_row, wr_col;
   logic                   a_we, b_wr;
   logic [AW-1:0]          a_waddr, a_raddr;
   logic [31:0]            a_rdata;
   logic                   emit_go, last_elem;
   logic [SH_W-1:0]        shifted;
   logic                   fits;

   mm_link_type            link [MAX_DIM+1];
   logic [IDXW-1:0]        k_link [MAX_DIM+1];
   logic signed [ACC_W-1:0] acc_chain [MAX_DIM+1];

   // Dimension registers out of range act as the nearest legal size.
   always_comb begin
      nr = (rows_a_ff == '0) ? DW'(1) :
           (int'(rows_a_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(rows_a_ff);
      nk = (inner_dim_ff == '0) ? DW'(1) :
           (int'(inner_dim_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(inner_dim_ff);
      nc = (cols_b_ff == '0) ? DW'(1) :
           (int'(cols_b_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cols_b_ff);
   end

   // Items are taken only while the sequencer is idle.
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Element writes outside the physical store are dropped.
   assign in_range = (int'(req_payload.row_index) < MAX_DIM) &&
                     (int'(req_payload.col_index) < MAX_DIM);
   assign wr_row   = IDXW'(req_payload.row_index);
   assign wr_col   = IDXW'(req_payload.col_index);
   assign a_we     = req_take && in_range && (req_payload.opcode == OP_WRITE_A);
   assign b_wr     = req_take && in_range && (req_payload.opcode == OP_WRITE_B);
   assign a_waddr  = AW'(int'(wr_row) * MAX_DIM + int'(wr_col));
   assign a_raddr  = AW'(int'(i_ff) * MAX_DIM + int'(k_ff));

   mm_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock (clock),
      .we    (a_we),
      .waddr (a_waddr),
      .wdata (req_payload.element_value),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   // The A element read in the previous cycle enters the first cell here.
   assign link[0].vld   = feed_vld_ff;
   assign link[0].first = feed_first_ff;
   assign link[0].a     = a_rdata;
   assign k_link[0]     = feed_k_ff;
   assign acc_chain[MAX_DIM] = '0;

   // Cell j owns column j of B. The A element moves one cell per cycle, and
   // during emission the accumulators shift one cell toward the output.
   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      mm_cell #(
         .MAX_DIM (MAX_DIM),
         .IDXW    (IDXW),
         .ACC_W   (ACC_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .link_in      (link[j]),
         .k_in         (k_link[j]),
         .link_out     (link[j+1]),
         .k_out        (k_link[j+1]),
         .b_we         (b_wr && (wr_col == IDXW'(j))),
         .b_row        (wr_row),
         .b_data       (req_payload.element_value),
         .shift_en     (emit_go),
         .acc_shift_in (acc_chain[j+1]),
         .acc_out      (acc_chain[j])
      );
   end

   // The exact sum is shifted down by 16, which floors, and is clipped to
   // 32 signed bits when the upper bits are not all copies of the sign.
   assign shifted = acc_chain[0][ACC_W-1:16];
   assign fits    = (&shifted[SH_W-1:31]) || !(|shifted[SH_W-1:31]);

   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign last_elem = (i_ff == IDXW'(nr - 1'b1)) && (j_ff == IDXW'(nc - 1'b1));

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      wait_in       = wait_ff;
      feed_vld_in   = 1'b0;
      feed_first_in = (k_ff == '0);
      feed_k_in     = k_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_payload.opcode == OP_COMPUTE)) begin
               state_in = ST_FEED;
               i_in     = '0;
               k_in     = '0;
            end
         end
         ST_FEED: begin
            feed_vld_in = 1'b1;
            k_in        = k_ff + 1'b1;
            if (k_ff == IDXW'(nk - 1'b1)) begin
               state_in = ST_WAIT;
               wait_in  = '0;
            end
         end
         ST_WAIT: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WW'(WAIT_CYC - 1)) begin
               state_in = ST_EMIT;
               j_in     = '0;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               j_in = j_ff + 1'b1;
               if (j_ff == IDXW'(nc - 1'b1)) begin
                  if (i_ff == IDXW'(nr - 1'b1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_FEED;
                     i_in     = i_ff + 1'b1;
                     k_in     = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (emit_go) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.out_row   = 3'(i_ff);
         rsp_payload_in.out_col   = 3'(j_ff);
         rsp_payload_in.out_value = fits ? shifted[31:0] :
                                    (shifted[SH_W-1] ? SAT_MIN : SAT_MAX);
         rsp_payload_in.saturated = !fits;
         rsp_payload_in.last      = last_elem;
      end
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         feed_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         feed_vld_ff  <= feed_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            unique case (csr_paddr[3:2])
               REG_ROWS_A:    rows_a_ff    <= csr_pwdata[DIM_CFG_W-1:0];
               REG_INNER_DIM: inner_dim_ff <= csr_pwdata[DIM_CFG_W-1:0];
               REG_COLS_B:    cols_b_ff    <= csr_pwdata[DIM_CFG_W-1:0];
               default: begin
               end
            endcase
         end
      end
      i_ff           <= i_in;
      k_ff           <= k_in;
      j_ff           <= j_in;
      wait_ff        <= wait_in;
      feed_first_ff  <= feed_first_in;
      feed_k_ff      <= feed_k_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ROWS_A:    csr_prdata = CSR_DW'(rows_a_ff);
         REG_INNER_DIM: csr_prdata = CSR_DW'(inner_dim_ff);
         REG_COLS_B:    csr_prdata = CSR_DW'(cols_b_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Every A element must have left the chain before a row is shifted out.
   a_chain_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !link[MAX_DIM].vld)
      else $error("A element still in the chain during emission");

   // An element leaving the last cell carries an inner index within range.
   a_tail_index: assert property (@(posedge clock) disable iff (reset)
      link[MAX_DIM].vld |-> (k_link[MAX_DIM] < nk))
      else $error("inner index out of range at the end of the chain");

   // The element marked last ends the product and returns the block to idle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit_go && last_elem) |=> (state_ff == ST_IDLE))
      else $error("product did not end after its last element");

   // While A is read, the row and inner counters stay inside the dimensions.
   a_feed_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEED) |-> ((k_ff < nk) && (i_ff < nr)))
      else $error("A read outside the configured dimensions");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the fixed-point matrix multiplier. It loads A and B
// elements, asks for products and checks every result element.
// Depends on mm_pkg and the matrix_multiply top level.
module tb_top;
   import mm_pkg::*;

   localparam int DIM = 8;
   // The package names no code for the fourth opcode; the block ignores it.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_AT = 100;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam logic signed [71:0] Q_MAX = 72'sh7FFF_FFFF;
   localparam logic signed [71:0] Q_MIN = -72'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mm_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mm_rsp_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   // Items waiting to be offered, and product elements waiting to come out.
   mm_req_type load_q[$];
   mm_rsp_type product_q[$];

   // The bench's own copy of the stores and of the dimension registers.
   logic signed [31:0] a_mem[DIM*DIM];
   logic signed [31:0] b_mem[DIM*DIM];
   logic [DIM_CFG_W-1:0] cfg_rows = DIM_RESET;
   logic [DIM_CFG_W-1:0] cfg_inner = DIM_RESET;
   logic [DIM_CFG_W-1:0] cfg_cols = DIM_RESET;

   // Entries the stimulus has already written; a product may only read these.
   bit a_written[DIM*DIM];
   bit b_written[DIM*DIM];

   int n_pushed = 0;
   int n_accepted = 0;
   int n_results = 0;
   int n_saturated = 0;
   int n_products = 0;
   int n_settings = 0;
   int n_errors = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   // When set, neither side inserts gaps: back-to-back traffic.
   bit steady = 1'b0;

   matrix_multiply #(
      .MAX_DIM(DIM)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // A register value of zero acts as one, anything above the store size as
   // the store size.
   function automatic int eff_dim(input logic [DIM_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return int'(v);
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int next_gap();
      int pick;
      pick = $urandom_range(99);
      if (steady || pick < 60) return 0;
      if (pick < 90) return $urandom_range(3, 1);
      if (pick < 98) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // Half the values are small enough that sums stay in range, the rest are
   // full-range words or the corner values of Q16.16.
   function automatic logic [31:0] pick_value();
      logic signed [31:0] v;
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         v = $urandom_range(32'h0008_0000);
         return v - 32'sh0004_0000;
      end
      if (pick < 80) return $urandom;
      case ($urandom_range(6))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return 32'h0000_0000;
         3: return 32'h0000_0001;
         4: return 32'hFFFF_FFFF;
         5: return 32'h0001_0000;
         default: return 32'hFFFF_0000;
      endcase
   endfunction

   // Indexes stay inside the configured size most of the time so that the
   // written data feeds later products.
   function automatic int pick_index(input int limit);
      if ($urandom_range(99) < 85) return $urandom_range(limit - 1);
      return $urandom_range(DIM - 1);
   endfunction

   // Works out every element of A*B at the current dimensions, in row-major
   // order, with a wide accumulator so that nothing is lost before the shift.
   task automatic expect_product();
      int nr, nk, nc;
      logic signed [71:0] acc, shifted;
      logic signed [63:0] prod;
      mm_rsp_type elem;
      nr = eff_dim(cfg_rows);
      nk = eff_dim(cfg_inner);
      nc = eff_dim(cfg_cols);
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
               prod = a_mem[i*DIM+k] * b_mem[k*DIM+j];
               acc = acc + prod;
            end
            // Arithmetic shift, so negative sums round toward minus infinity.
            shifted = acc >>> 16;
            elem.out_row = 3'(i);
            elem.out_col = 3'(j);
            elem.saturated = 1'b1;
            if (shifted > Q_MAX) begin
               elem.out_value = SAT_MAX;
            end else if (shifted < Q_MIN) begin
               elem.out_value = SAT_MIN;
            end else begin
               elem.out_value = shifted[31:0];
               elem.saturated = 1'b0;
            end
            elem.last = (i == nr - 1) && (j == nc - 1);
            product_q.push_back(elem);
         end
      end
   endtask

   // Applies one accepted item to the bench's copy of the stores.
   task automatic track_item(input mm_req_type item);
      case (item.opcode)
         OP_WRITE_A: a_mem[item.row_index*DIM+item.col_index] = item.element_value;
         OP_WRITE_B: b_mem[item.row_index*DIM+item.col_index] = item.element_value;
         OP_COMPUTE: expect_product();
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         n_errors++;
      end
   endtask

   task automatic queue_item(input logic [1:0] op, input int row, input int col,
                             input logic [31:0] value);
      mm_req_type item;
      item.opcode = op;
      item.row_index = 3'(row);
      item.col_index = 3'(col);
      item.element_value = value;
      if (op == OP_WRITE_A) a_written[row*DIM+col] = 1'b1;
      if (op == OP_WRITE_B) b_written[row*DIM+col] = 1'b1;
      load_q.push_back(item);
      n_pushed++;
   endtask

   // Writes any entry the product would read but that was never loaded, then
   // asks for the product with junk in the unused fields.
   task automatic queue_product();
      int nr, nk, nc;
      nr = eff_dim(cfg_rows);
      nk = eff_dim(cfg_inner);
      nc = eff_dim(cfg_cols);
      for (int i = 0; i < nr; i++)
         for (int k = 0; k < nk; k++)
            if (!a_written[i*DIM+k]) queue_item(OP_WRITE_A, i, k, pick_value());
      for (int k = 0; k < nk; k++)
         for (int j = 0; j < nc; j++)
            if (!b_written[k*DIM+j]) queue_item(OP_WRITE_B, k, j, pick_value());
      queue_item(OP_COMPUTE, $urandom_range(DIM - 1), $urandom_range(DIM - 1), $urandom);
      n_products++;
   endtask

   // Random traffic: element loads with random content and products, with a
   // sprinkle of ignored opcodes. A product always closes the phase.
   task automatic queue_random(input int count);
      int pick, nr, nk, nc;
      nr = eff_dim(cfg_rows);
      nk = eff_dim(cfg_inner);
      nc = eff_dim(cfg_cols);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 40)
            queue_item(OP_WRITE_A, pick_index(nr), pick_index(nk), pick_value());
         else if (pick < 80)
            queue_item(OP_WRITE_B, pick_index(nk), pick_index(nc), pick_value());
         else if (pick < 92)
            queue_product();
         else
            queue_item(OP_UNUSED, $urandom_range(DIM - 1), $urandom_range(DIM - 1),
                       $urandom);
      end
      queue_product();
   endtask

   // Register write: setup cycle, then access cycle; the register takes the
   // value at the edge that ends the access cycle.
   task automatic csr_write(input logic [1:0] idx, input logic [DIM_CFG_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ROWS_A: cfg_rows = value;
         REG_INNER_DIM: cfg_inner = value;
         REG_COLS_B: cfg_cols = value;
         default: ;
      endcase
   endtask

   task automatic set_dims(input logic [DIM_CFG_W-1:0] rows,
                           input logic [DIM_CFG_W-1:0] inner,
                           input logic [DIM_CFG_W-1:0] cols);
      csr_write(REG_ROWS_A, rows);
      csr_write(REG_INNER_DIM, inner);
      csr_write(REG_COLS_B, cols);
      n_settings++;
   endtask

   // Waits until every item is taken and every element has come out, then
   // lets the block finish any trailing loads before registers change.
   task automatic drain();
      while (n_accepted != n_pushed || product_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: presents the next queued item once the current one is taken,
   // with a random gap after each item. Acceptance is judged on the values
   // seen at the edge, before this edge's updates take effect.
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_item(req_payload);
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (load_q.size() != 0) begin
               req_payload <= load_q.pop_front();
               req_valid <= 1'b1;
               send_gap = next_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each taken result element with the oldest expected
   // one and drives the result-side stall. Once, after enough elements have
   // come out, it holds the result side off for a long stretch so that the
   // block backs up into its input while the driver keeps offering items.
   always @(posedge clock) begin : monitor
      mm_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (rsp_payload.saturated) n_saturated++;
            if (product_q.size() == 0) begin
               $error("unexpected result element at row %0d col %0d",
                      rsp_payload.out_row, rsp_payload.out_col);
               n_errors++;
            end else begin
               want = product_q.pop_front();
               check_field("out_row", 32'(want.out_row), 32'(rsp_payload.out_row));
               check_field("out_col", 32'(want.out_col), 32'(rsp_payload.out_col));
               check_field("out_value", want.out_value, rsp_payload.out_value);
               check_field("saturated", 32'(want.saturated), 32'(rsp_payload.saturated));
               check_field("last", 32'(want.last), 32'(rsp_payload.last));
            end
            if (!hold_done && n_results >= HOLD_AT) begin
               hold_done = 1'b1;
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = next_gap();
         end
      end
   end

   // Watchdog: a run that stops moving on both channels for too long is hung.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at 2x2x2. First every sign combination of the largest
      // magnitudes, so each element saturates one way or the other.
      set_dims(4'd2, 4'd2, 4'd2);
      queue_item(OP_WRITE_A, 0, 0, SAT_MAX);
      queue_item(OP_WRITE_A, 0, 1, SAT_MAX);
      queue_item(OP_WRITE_A, 1, 0, SAT_MIN);
      queue_item(OP_WRITE_A, 1, 1, SAT_MIN);
      queue_item(OP_WRITE_B, 0, 0, SAT_MAX);
      queue_item(OP_WRITE_B, 1, 0, SAT_MAX);
      queue_item(OP_WRITE_B, 0, 1, SAT_MIN);
      queue_item(OP_WRITE_B, 1, 1, SAT_MIN);
      queue_item(OP_COMPUTE, 7, 7, 32'hFFFF_FFFF);
      n_products++;
      // The ignored opcode, then loads at the far corner of the store, which
      // lie outside the configured size and must not disturb the product.
      queue_item(OP_UNUSED, 7, 7, SAT_MIN);
      queue_item(OP_WRITE_A, 7, 7, 32'hFFFF_FFFF);
      queue_item(OP_WRITE_B, 7, 7, SAT_MAX);
      // Small values, including the least negative one, so the shift has to
      // round toward minus infinity.
      queue_item(OP_WRITE_A, 0, 0, 32'hFFFF_FFFF);
      queue_item(OP_WRITE_A, 0, 1, 32'h0000_0000);
      queue_item(OP_WRITE_A, 1, 0, 32'h0001_8000);
      queue_item(OP_WRITE_A, 1, 1, 32'hFFFF_0000);
      queue_item(OP_WRITE_B, 0, 0, 32'h0000_0001);
      queue_item(OP_WRITE_B, 0, 1, 32'h0001_0000);
      queue_item(OP_WRITE_B, 1, 0, 32'hFFFF_8000);
      queue_item(OP_WRITE_B, 1, 1, 32'h0000_0003);
      queue_item(OP_COMPUTE, 0, 0, 32'h0000_0000);
      n_products++;
      drain();

      // Random phases over several settings: an uneven shape, the largest
      // size (where the long result-side hold falls), the smallest size run
      // back to back, register values outside the legal range, then random.
      set_dims(4'd3, 4'd5, 4'd2);
      queue_random(70);
      drain();
      set_dims(4'd8, 4'd8, 4'd8);
      queue_random(70);
      drain();
      steady = 1'b1;
      set_dims(4'd1, 4'd1, 4'd1);
      queue_random(70);
      drain();
      steady = 1'b0;
      set_dims(4'd0, 4'd15, 4'd9);
      queue_random(70);
      drain();
      repeat (2) begin
         set_dims(4'($urandom_range(DIM, 1)), 4'($urandom_range(DIM, 1)),
                  4'($urandom_range(DIM, 1)));
         queue_random(70);
         drain();
      end

      if (product_q.size() != 0) begin
         $error("%0d result elements never arrived", product_q.size());
         n_errors++;
      end
      $display("Run covered %0d items and %0d products over %0d dimension settings,",
               n_accepted, n_products, n_settings);
      $display("checking %0d result elements, %0d of them saturated.",
               n_results, n_saturated);
      if (n_errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
